@@ hw/rtl/sfd_pkg.sv @@
// Package for the stereo feedback delay: configuration record, sequencer
// states, datapath command/status records and Q1.16 helpers.
// No dependencies; used by sfd_ctrl, sfd_datapath and the top level.
package sfd_pkg;

    localparam int FIELD_W    = 24;   // width of one sample field on the streams
    localparam int GAIN_W     = 17;   // Q1.16 gain, 65536 is unity
    localparam int DELAY_W    = 16;   // delay limits in samples
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [GAIN_W-1:0] UNITY    = 17'h10000;
    localparam logic [GAIN_W-1:0] HALF_LSB = 17'h08000;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FEEDBACK   = 3'd0,
        REG_TIME       = 3'd1,
        REG_DELAY_MIN  = 3'd2,
        REG_DELAY_MAX  = 3'd3,
        REG_INPUT_GAIN = 3'd4,
        REG_DEZAP      = 3'd5,
        REG_FADE_STEP  = 3'd6,
        REG_FADE_POLE  = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  feedback_setting;
        logic [GAIN_W-1:0]  time_setting;
        logic [DELAY_W-1:0] delay_min;
        logic [DELAY_W-1:0] delay_max;
        logic [GAIN_W-1:0]  input_gain;
        logic [GAIN_W-1:0]  dezap_coef;
        logic [GAIN_W-1:0]  fade_step;
        logic [GAIN_W-1:0]  fade_pole;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        feedback_setting: 17'd32768,
        time_setting:     17'd32768,
        delay_min:        16'd2400,
        delay_max:        16'd64800,
        input_gain:       17'd65536,
        dezap_coef:       17'd64,
        fade_step:        17'd64,
        fade_pole:        17'd65024
    };

    // Sequencer states: ring clear, idle, then one per step of the per-sample schedule
    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FB_MUL0,
        ST_FB_MUL1,
        ST_SPAN_MUL,
        ST_FB_WR,
        ST_UPDATE,
        ST_RING_RD,
        ST_FADE_WR,
        ST_DLY_L,
        ST_DLY_R,
        ST_OUT_L,
        ST_OUT_R,
        ST_MIX_L,
        ST_STORE_L,
        ST_MIX_R,
        ST_DONE
    } state_t;

    // Operand pair for the shared multiplier
    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_FB_HOLD,   // (1 - coef) * smoothed feedback
        MUL_FB_SET,    // coef * feedback setting
        MUL_SPAN,      // time setting * delay span
        MUL_FADE,      // fade pole * fade gain
        MUL_DLY_L,     // fade gain * delayed left
        MUL_DLY_R,
        MUL_IN_L,      // input gain * left input
        MUL_IN_R,
        MUL_FBK_L,     // feedback * left output
        MUL_FBK_R
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_FADE       // product plus the fade target term
    } acc_op_t;

    // Destination of the rounded accumulator
    typedef enum logic [2:0] {
        WR_NONE,
        WR_FB,
        WR_FADE,
        WR_Y_L,
        WR_Y_R,
        WR_W_L
    } wr_sel_t;

    typedef struct packed {
        mul_sel_t mul;
        acc_op_t  acc;
        wr_sel_t  wr;
        logic     capture;    // latch the input pair
        logic     update;     // offset, write position and fade count
        logic     ring_rd;
        logic     ring_wr;
        logic     clear_wr;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
    } status_t;

    function automatic logic [GAIN_W-1:0] clamp_unity(input logic [GAIN_W-1:0] v);
        return (v > UNITY) ? UNITY : v;
    endfunction

endpackage

@@ hw/rtl/sfd_ctrl.sv @@
// Sequencer for the stereo feedback delay: walks the per-sample schedule
// and owns the stream handshakes. Depends on sfd_pkg.
module sfd_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  sfd_pkg::status_t status,
    output sfd_pkg::cmd_t    cmd
);

    sfd_pkg::state_t state_reg;
    sfd_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sfd_pkg::ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            sfd_pkg::ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (status.clear_last)
                begin
                    state_next = sfd_pkg::ST_IDLE;
                end
            end
            sfd_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = sfd_pkg::ST_FB_MUL0;
                end
            end
            sfd_pkg::ST_FB_MUL0:
            begin
                cmd.mul    = sfd_pkg::MUL_FB_HOLD;
                state_next = sfd_pkg::ST_FB_MUL1;
            end
            sfd_pkg::ST_FB_MUL1:
            begin
                cmd.mul    = sfd_pkg::MUL_FB_SET;
                cmd.acc    = sfd_pkg::ACC_LOAD;
                state_next = sfd_pkg::ST_SPAN_MUL;
            end
            sfd_pkg::ST_SPAN_MUL:
            begin
                cmd.mul    = sfd_pkg::MUL_SPAN;
                cmd.acc    = sfd_pkg::ACC_ADD;
                state_next = sfd_pkg::ST_FB_WR;
            end
            sfd_pkg::ST_FB_WR:
            begin
                cmd.wr     = sfd_pkg::WR_FB;
                cmd.acc    = sfd_pkg::ACC_LOAD;
                state_next = sfd_pkg::ST_UPDATE;
            end
            sfd_pkg::ST_UPDATE:
            begin
                cmd.update = 1'b1;
                cmd.mul    = sfd_pkg::MUL_FADE;
                state_next = sfd_pkg::ST_RING_RD;
            end
            sfd_pkg::ST_RING_RD:
            begin
                cmd.ring_rd = 1'b1;
                cmd.acc     = sfd_pkg::ACC_FADE;
                state_next  = sfd_pkg::ST_FADE_WR;
            end
            sfd_pkg::ST_FADE_WR:
            begin
                cmd.wr     = sfd_pkg::WR_FADE;
                state_next = sfd_pkg::ST_DLY_L;
            end
            sfd_pkg::ST_DLY_L:
            begin
                cmd.mul    = sfd_pkg::MUL_DLY_L;
                state_next = sfd_pkg::ST_DLY_R;
            end
            sfd_pkg::ST_DLY_R:
            begin
                cmd.mul    = sfd_pkg::MUL_DLY_R;
                cmd.acc    = sfd_pkg::ACC_LOAD;
                state_next = sfd_pkg::ST_OUT_L;
            end
            sfd_pkg::ST_OUT_L:
            begin
                cmd.wr     = sfd_pkg::WR_Y_L;
                cmd.acc    = sfd_pkg::ACC_LOAD;
                cmd.mul    = sfd_pkg::MUL_IN_L;
                state_next = sfd_pkg::ST_OUT_R;
            end
            sfd_pkg::ST_OUT_R:
            begin
                cmd.wr     = sfd_pkg::WR_Y_R;
                cmd.mul    = sfd_pkg::MUL_FBK_L;
                cmd.acc    = sfd_pkg::ACC_LOAD;
                state_next = sfd_pkg::ST_MIX_L;
            end
            sfd_pkg::ST_MIX_L:
            begin
                cmd.mul    = sfd_pkg::MUL_IN_R;
                cmd.acc    = sfd_pkg::ACC_ADD;
                state_next = sfd_pkg::ST_STORE_L;
            end
            sfd_pkg::ST_STORE_L:
            begin
                cmd.wr     = sfd_pkg::WR_W_L;
                cmd.mul    = sfd_pkg::MUL_FBK_R;
                cmd.acc    = sfd_pkg::ACC_LOAD;
                state_next = sfd_pkg::ST_MIX_R;
            end
            sfd_pkg::ST_MIX_R:
            begin
                cmd.acc    = sfd_pkg::ACC_ADD;
                state_next = sfd_pkg::ST_DONE;
            end
            sfd_pkg::ST_DONE:
            begin
                // hold the ring write until the result register frees up
                cmd.ring_wr = 1'b1;
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = sfd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sfd_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten while still pending");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == sfd_pkg::ST_FB_MUL0))
        else $error("accepted transfer did not start the schedule");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == sfd_pkg::ST_DONE))
        else $error("result raised outside the final step");

endmodule

@@ hw/rtl/sfd_datapath.sv @@
// Datapath for the stereo feedback delay: shared multiply-accumulate,
// gain and fade state, ring memory and result registers. Depends on sfd_pkg.
module sfd_datapath
#(
    parameter int RING_DEPTH  = 65536,
    parameter int SAMPLE_BITS = 24
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  sfd_pkg::cfg_t                cfg,
    input  sfd_pkg::cmd_t                cmd,
    output sfd_pkg::status_t             status,
    input  logic [sfd_pkg::FIELD_W-1:0]  in_left,
    input  logic [sfd_pkg::FIELD_W-1:0]  in_right,
    output logic [sfd_pkg::FIELD_W-1:0]  out_left,
    output logic [sfd_pkg::FIELD_W-1:0]  out_right
);

    localparam int AW  = $clog2(RING_DEPTH);
    localparam int SB  = SAMPLE_BITS;
    localparam int IW  = (SB > sfd_pkg::FIELD_W) ? SB : sfd_pkg::FIELD_W;
    localparam int BW  = (SB > 18) ? SB : 18;
    localparam int PW  = 18 + BW;
    localparam int ACW = PW + 1;
    localparam int RW  = ACW - 16;
    localparam int GW  = sfd_pkg::GAIN_W;

    localparam logic [AW-1:0]          LAST_ADDR = AW'(RING_DEPTH - 1);
    localparam logic [AW:0]            DEPTH_W   = (AW + 1)'(RING_DEPTH);
    localparam logic signed [RW-1:0]   SAT_HI    = RW'((64'sd1 <<< (SB - 1)) - 64'sd1);
    localparam logic signed [RW-1:0]   SAT_LO    = ~SAT_HI;

    // Reduce a 16-bit offset modulo the ring depth by compare and subtract (exact for RING_DEPTH of at least 512)
    function automatic logic [AW-1:0] ring_mod(input logic [15:0] v);
        logic [31:0] r;
        r = 32'(v);
        for (int k = 6; k >= 0; k--)
        begin
            if (r >= (32'(RING_DEPTH) << k))
            begin
                r = r - (32'(RING_DEPTH) << k);
            end
        end
        return r[AW-1:0];
    endfunction

    logic [2*SB-1:0] ring_mem [RING_DEPTH];

    // control state
    logic [GW-1:0]  sf_reg;
    logic [GW-1:0]  fg_reg;
    logic [GW-1:0]  fc_reg;
    logic [GW-1:0]  applied_reg;
    logic           pending_reg;
    logic [AW-1:0]  wp_reg;
    logic [AW-1:0]  off_reg;
    logic [AW-1:0]  clr_reg;

    // payload
    logic signed [SB-1:0]  x_l_reg;
    logic signed [SB-1:0]  x_r_reg;
    logic signed [SB-1:0]  y_l_reg;
    logic signed [SB-1:0]  y_r_reg;
    logic signed [SB-1:0]  w_l_reg;
    logic signed [PW-1:0]  p_reg;
    logic signed [ACW-1:0] acc_reg;
    logic [2*SB-1:0]       q_reg;
    logic [sfd_pkg::FIELD_W-1:0] out_l_reg;
    logic [sfd_pkg::FIELD_W-1:0] out_r_reg;

    logic [GW-1:0]         fs_c;
    logic [GW-1:0]         ts_c;
    logic [GW-1:0]         ig_c;
    logic [GW-1:0]         coef_c;
    logic [GW-1:0]         step_c;
    logic [GW-1:0]         pole_c;
    logic [GW-1:0]         coef_inv;
    logic [GW-1:0]         pole_inv;
    logic [15:0]           span;
    logic [GW-1:0]         mul_a;
    logic signed [BW-1:0]  mul_b;
    logic signed [PW-1:0]  prod;
    logic signed [ACW-1:0] fade_term;
    logic signed [ACW-1:0] acc_next;
    logic [ACW-1:0]        acc_sum;
    logic signed [RW-1:0]  rnd;
    logic signed [SB-1:0]  rnd_sat;
    logic [GW-1:0]         rnd_gain;
    logic                  recompute;
    logic [15:0]           off_raw;
    logic [AW-1:0]         off_new;
    logic [GW-1:0]         fc_base;
    logic [GW:0]           fc_sum;
    logic [GW-1:0]         fc_new;
    logic [AW-1:0]         wp_next;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         mem_waddr;
    logic [2*SB-1:0]       mem_wdata;
    logic                  mem_we;
    logic signed [SB-1:0]  q_l;
    logic signed [SB-1:0]  q_r;
    logic [IW-1:0]         in_l_ext;
    logic [IW-1:0]         in_r_ext;

    assign fs_c     = sfd_pkg::clamp_unity(cfg.feedback_setting);
    assign ts_c     = sfd_pkg::clamp_unity(cfg.time_setting);
    assign ig_c     = sfd_pkg::clamp_unity(cfg.input_gain);
    assign coef_c   = sfd_pkg::clamp_unity(cfg.dezap_coef);
    assign step_c   = sfd_pkg::clamp_unity(cfg.fade_step);
    assign pole_c   = sfd_pkg::clamp_unity(cfg.fade_pole);
    assign coef_inv = sfd_pkg::UNITY - coef_c;
    assign pole_inv = sfd_pkg::UNITY - pole_c;
    assign span     = (cfg.delay_max > cfg.delay_min) ? (cfg.delay_max - cfg.delay_min) : 16'd0;

    assign q_l = $signed(q_reg[SB-1:0]);
    assign q_r = $signed(q_reg[2*SB-1:SB]);

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul)
            sfd_pkg::MUL_FB_HOLD:
            begin
                mul_a = coef_inv;
                mul_b = $signed(BW'(sf_reg));
            end
            sfd_pkg::MUL_FB_SET:
            begin
                mul_a = coef_c;
                mul_b = $signed(BW'(fs_c));
            end
            sfd_pkg::MUL_SPAN:
            begin
                mul_a = ts_c;
                mul_b = $signed(BW'(span));
            end
            sfd_pkg::MUL_FADE:
            begin
                mul_a = pole_c;
                mul_b = $signed(BW'(fg_reg));
            end
            sfd_pkg::MUL_DLY_L:
            begin
                mul_a = fg_reg;
                mul_b = BW'(q_l);
            end
            sfd_pkg::MUL_DLY_R:
            begin
                mul_a = fg_reg;
                mul_b = BW'(q_r);
            end
            sfd_pkg::MUL_IN_L:
            begin
                mul_a = ig_c;
                mul_b = BW'(x_l_reg);
            end
            sfd_pkg::MUL_IN_R:
            begin
                mul_a = ig_c;
                mul_b = BW'(x_r_reg);
            end
            sfd_pkg::MUL_FBK_L:
            begin
                mul_a = sf_reg;
                mul_b = BW'(y_l_reg);
            end
            sfd_pkg::MUL_FBK_R:
            begin
                mul_a = sf_reg;
                mul_b = BW'(y_r_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = $signed({1'b0, mul_a}) * mul_b;

    // target of the fade low-pass is unity once the counter has saturated
    assign fade_term = (fc_reg == sfd_pkg::UNITY) ? $signed(ACW'({pole_inv, 16'h0000})) : '0;

    always_comb
    begin
        case (cmd.acc)
            sfd_pkg::ACC_LOAD: acc_next = ACW'(p_reg);
            sfd_pkg::ACC_ADD:  acc_next = acc_reg + ACW'(p_reg);
            sfd_pkg::ACC_FADE: acc_next = ACW'(p_reg) + fade_term;
            default:           acc_next = acc_reg;
        endcase
    end

    // round to nearest, ties upward, then saturate to the sample width
    assign acc_sum  = acc_reg + ACW'(sfd_pkg::HALF_LSB);
    assign rnd      = $signed(acc_sum[ACW-1:16]);
    assign rnd_gain = rnd[GW-1:0];

    always_comb
    begin
        if (rnd > SAT_HI)
        begin
            rnd_sat = SAT_HI[SB-1:0];
        end
        else if (rnd < SAT_LO)
        begin
            rnd_sat = SAT_LO[SB-1:0];
        end
        else
        begin
            rnd_sat = rnd[SB-1:0];
        end
    end

    // per-sample update of offset, write position and fade counter
    assign recompute = pending_reg || (cfg.time_setting != applied_reg);
    assign off_raw   = cfg.delay_min + acc_reg[31:16];
    assign off_new   = recompute ? ring_mod(off_raw) : off_reg;
    assign fc_base   = recompute ? '0 : fc_reg;
    assign fc_sum    = (GW + 1)'(fc_base) + (GW + 1)'(step_c);
    assign fc_new    = (fc_sum > (GW + 1)'(sfd_pkg::UNITY)) ? sfd_pkg::UNITY : fc_sum[GW-1:0];
    assign wp_next   = (wp_reg == LAST_ADDR) ? '0 : wp_reg + 1'b1;

    assign rd_addr = (wp_reg >= off_reg) ? (wp_reg - off_reg)
                                         : AW'(DEPTH_W + {1'b0, wp_reg} - {1'b0, off_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sf_reg      <= '0;
            fg_reg      <= '0;
            fc_reg      <= '0;
            applied_reg <= '0;
            pending_reg <= 1'b1;
            wp_reg      <= '0;
            off_reg     <= '0;
            clr_reg     <= '0;
        end
        else
        begin
            if (cmd.clear_wr)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.wr == sfd_pkg::WR_FB)
            begin
                sf_reg <= rnd_gain;
            end
            if (cmd.wr == sfd_pkg::WR_FADE)
            begin
                fg_reg <= rnd_gain;
            end
            if (cmd.update)
            begin
                off_reg <= off_new;
                fc_reg  <= fc_new;
                wp_reg  <= wp_next;
                if (recompute)
                begin
                    applied_reg <= cfg.time_setting;
                    pending_reg <= 1'b0;
                end
            end
        end
    end

    assign in_l_ext = IW'(in_left);
    assign in_r_ext = IW'(in_right);

    always_ff @(posedge clk)
    begin
        p_reg   <= prod;
        acc_reg <= acc_next;
        if (cmd.capture)
        begin
            x_l_reg <= $signed(in_l_ext[SB-1:0]);
            x_r_reg <= $signed(in_r_ext[SB-1:0]);
        end
        if (cmd.wr == sfd_pkg::WR_Y_L)
        begin
            y_l_reg <= rnd_sat;
        end
        if (cmd.wr == sfd_pkg::WR_Y_R)
        begin
            y_r_reg <= rnd_sat;
        end
        if (cmd.wr == sfd_pkg::WR_W_L)
        begin
            w_l_reg <= rnd_sat;
        end
        if (cmd.out_load)
        begin
            out_l_reg <= sfd_pkg::FIELD_W'(y_l_reg);
            out_r_reg <= sfd_pkg::FIELD_W'(y_r_reg);
        end
    end

    // ring memory: one write port, one registered read port
    assign mem_we    = cmd.clear_wr || cmd.ring_wr;
    assign mem_waddr = cmd.clear_wr ? clr_reg : wp_reg;
    assign mem_wdata = cmd.clear_wr ? '0 : {rnd_sat, w_l_reg};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.ring_rd)
        begin
            q_reg <= ring_mem[rd_addr];
        end
    end

    assign status.clear_last = (clr_reg == LAST_ADDR);
    assign out_left          = out_l_reg;
    assign out_right         = out_r_reg;

    a_fade_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.update && recompute) |=> (fc_reg == $past(step_c)))
        else $error("fade counter did not restart on a time change");

    a_gains_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (fg_reg <= sfd_pkg::UNITY) && (sf_reg <= sfd_pkg::UNITY)
        && (fc_reg <= sfd_pkg::UNITY))
        else $error("gain state above unity");

    a_ring_index: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ring_rd |-> ((32'(rd_addr) < 32'(RING_DEPTH)) && !cmd.clear_wr))
        else $error("ring read out of range or during clear");

endmodule

@@ hw/rtl/stereo_feedback_delay_top.sv @@
// Top level of the stereo feedback delay: stream ports, configuration
// registers, sequencer and datapath. Depends on sfd_pkg, sfd_ctrl, sfd_datapath.
// Each result is loaded into the output register in ST_DONE, the last step.
// A new sample pair is taken only when idle; the single shared 18 x SAMPLE_BITS
// multiply-accumulate issues ten products per pair over a 15-step schedule.
// Reset: control state clears and configuration loads defaults at once; the ring then
// clears address by address with s_axis_tready low (config writes are still taken).
module stereo_feedback_delay_top
#(
    parameter int RING_DEPTH  = 65536,
    parameter int SAMPLE_BITS = 24
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // input pair
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [2*sfd_pkg::FIELD_W-1:0]     s_axis_tdata,   // left_in, right_in
    // delayed pair
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [2*sfd_pkg::FIELD_W-1:0]     m_axis_tdata,   // left_out, right_out
    // configuration writes
    input  logic                              cfg_wr_en,
    input  logic [sfd_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [sfd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    sfd_pkg::cfg_t    cfg_reg;
    sfd_pkg::cfg_t    cfg_next;
    sfd_pkg::cmd_t    cmd;
    sfd_pkg::status_t status;

    logic [sfd_pkg::FIELD_W-1:0] out_left;
    logic [sfd_pkg::FIELD_W-1:0] out_right;

    // Configuration registers: written only while no sample is in flight (the user's rule,
    // not enforced here), so the datapath reads them directly without any shadowing.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (sfd_pkg::cfg_reg_t'(cfg_addr))
                sfd_pkg::REG_FEEDBACK:   cfg_next.feedback_setting = cfg_wdata;
                sfd_pkg::REG_TIME:       cfg_next.time_setting     = cfg_wdata;
                sfd_pkg::REG_DELAY_MIN:  cfg_next.delay_min        = cfg_wdata[15:0];
                sfd_pkg::REG_DELAY_MAX:  cfg_next.delay_max        = cfg_wdata[15:0];
                sfd_pkg::REG_INPUT_GAIN: cfg_next.input_gain       = cfg_wdata;
                sfd_pkg::REG_DEZAP:      cfg_next.dezap_coef       = cfg_wdata;
                sfd_pkg::REG_FADE_STEP:  cfg_next.fade_step        = cfg_wdata;
                sfd_pkg::REG_FADE_POLE:  cfg_next.fade_pole        = cfg_wdata;
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= sfd_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Sequencer: takes a transfer only when idle, then steps the datapath
    // through the schedule and hands the pair to the output register. The
    // output register decouples the two sides, so a waiting result does not
    // block the next input transfer until its own result is ready.
    sfd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath: smoothing, offset recompute, fade, ring read and write-back.
    // Left sample sits in the low half of each stream word.
    sfd_datapath
    #(
        .RING_DEPTH  (RING_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd       (cmd),
        .status    (status),
        .in_left   (s_axis_tdata[sfd_pkg::FIELD_W-1:0]),
        .in_right  (s_axis_tdata[2*sfd_pkg::FIELD_W-1:sfd_pkg::FIELD_W]),
        .out_left  (out_left),
        .out_right (out_right)
    );

    assign m_axis_tdata = {out_right, out_left};

endmodule
